/* hdl/cld_pkg.sv */
// Package: shared types and constants for the content-length deframer.
package cld_pkg;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic        is_body;
        logic [7:0]  body_byte;
        logic        done_res;
        logic [1:0]  status;
        logic [31:0] length;
    } out_item_t;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_HDR   = 2'd1;
    localparam logic [1:0] ST_EOS   = 2'd2;
    localparam logic [1:0] ST_TRUNC = 2'd3;

    localparam logic       CFG_MAX_HDR  = 1'b0;
    localparam logic       CFG_MAX_BODY = 1'b1;

    localparam logic [20:0] HDR_RESET  = 21'd65536;
    localparam logic [31:0] BODY_RESET = 32'd16777216;
    localparam logic [20:0] COUNT_MAX  = 21'h1FFFFF;
    localparam logic [31:0] TERM_WORD  = 32'h0D0A0D0A;
    localparam int          NAME_LEN   = 14;
    localparam int          QDEPTH     = 4;
    localparam int          QAW        = 2;

    typedef enum logic [7:0] {
        LP_START  = 8'b0000_0001,
        LP_NLEAD  = 8'b0000_0010,
        LP_NBODY  = 8'b0000_0100,
        LP_NTRAIL = 8'b0000_1000,
        LP_VLEAD  = 8'b0001_0000,
        LP_VDIG   = 8'b0010_0000,
        LP_VTRAIL = 8'b0100_0000,
        LP_IGNORE = 8'b1000_0000
    } line_phase_t;

    function automatic logic [7:0] name_char_at(input logic [3:0] i);
        logic [7:0] c;
        begin
            unique case (i)
                4'd0:    c = "c";
                4'd1:    c = "o";
                4'd2:    c = "n";
                4'd3:    c = "t";
                4'd4:    c = "e";
                4'd5:    c = "n";
                4'd6:    c = "t";
                4'd7:    c = "-";
                4'd8:    c = "l";
                4'd9:    c = "e";
                4'd10:   c = "n";
                4'd11:   c = "g";
                4'd12:   c = "t";
                4'd13:   c = "h";
                default: c = 8'h00;
            endcase
            return c;
        end
    endfunction

endpackage

/* hdl/cld_front.sv */
// Front part: header parser, body counter, result generation per item.
module cld_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  cld_pkg::in_item_t in_item,
    input  logic [20:0]       max_header_bytes,
    input  logic [31:0]       max_body_bytes,
    output logic              res_valid,
    output cld_pkg::out_item_t res_item
);
    import cld_pkg::*;

    logic        body_reg, body_next;
    logic [31:0] last4_reg, last4_next;
    logic [20:0] hcount_reg, hcount_next;
    logic        pcr_reg, pcr_next;
    line_phase_t lp_reg, lp_next;
    logic [3:0]  nidx_reg, nidx_next;
    logic        nmis_reg, nmis_next;
    logic [32:0] acc_reg, acc_next;
    logic        vbad_reg, vbad_next;
    logic        vovf_reg, vovf_next;
    logic        herr_reg, herr_next;
    logic        lfound_reg, lfound_next;
    logic [31:0] dlen_reg, dlen_next;
    logic [31:0] brem_reg, brem_next;

    // line character unit; called up to twice (pending CR then byte)
    typedef struct packed {
        line_phase_t lp;
        logic [3:0]  nidx;
        logic        nmis;
        logic [32:0] acc;
        logic        vbad;
        logic        vovf;
    } lstate_t;

    function automatic lstate_t line_char(input lstate_t s, input logic [7:0] c);
        lstate_t    r;
        logic       ws, colon, digit;
        logic [7:0] lc;
        logic [36:0] prod;
        begin
            r     = s;
            ws    = (c == 8'h20) || (c == 8'h09);
            colon = (c == 8'h3A);
            digit = (c >= 8'h30) && (c <= 8'h39);
            lc    = (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
            prod  = {4'd0, s.acc} * 37'd10 + {33'd0, c[3:0]};
            unique case (s.lp)
                LP_START, LP_NLEAD, LP_NBODY, LP_NTRAIL:
                begin
                    if (colon)
                        r.lp = (!s.nmis && s.nidx == 4'(NAME_LEN)) ? LP_VLEAD : LP_IGNORE;
                    else if (ws)
                    begin
                        if (s.lp == LP_START) r.lp = LP_NLEAD;
                        else if (s.lp == LP_NBODY) r.lp = LP_NTRAIL;
                    end
                    else
                    begin
                        if (s.lp == LP_NTRAIL) r.nmis = 1'b1;
                        if (s.nidx < 4'(NAME_LEN) && lc == name_char_at(s.nidx))
                            r.nidx = s.nidx + 4'd1;
                        else
                            r.nmis = 1'b1;
                        r.lp = LP_NBODY;
                    end
                end
                LP_VLEAD, LP_VDIG:
                begin
                    if (digit)
                    begin
                        if (prod > 37'hFFFFFFFF)
                        begin
                            r.vovf = 1'b1;
                            r.acc  = 33'h100000000;
                        end
                        else
                            r.acc = prod[32:0];
                        r.lp = LP_VDIG;
                    end
                    else if (ws)
                    begin
                        if (s.lp == LP_VDIG) r.lp = LP_VTRAIL;
                    end
                    else
                        r.vbad = 1'b1;
                end
                LP_VTRAIL: if (!ws) r.vbad = 1'b1;
                default: ;
            endcase
            return r;
        end
    endfunction

    lstate_t ls0, ls1, ls2;
    logic [7:0] b;
    logic       le_err, le_found;
    logic       term;

    always_comb
    begin
        b           = in_item.data_byte;
        body_next   = body_reg;
        last4_next  = last4_reg;
        hcount_next = hcount_reg;
        pcr_next    = pcr_reg;
        lp_next     = lp_reg;
        nidx_next   = nidx_reg;
        nmis_next   = nmis_reg;
        acc_next    = acc_reg;
        vbad_next   = vbad_reg;
        vovf_next   = vovf_reg;
        herr_next   = herr_reg;
        lfound_next = lfound_reg;
        dlen_next   = dlen_reg;
        brem_next   = brem_reg;
        res_valid   = 1'b0;
        res_item    = '0;
        ls0 = '{lp: lp_reg, nidx: nidx_reg, nmis: nmis_reg, acc: acc_reg,
                vbad: vbad_reg, vovf: vovf_reg};
        ls1 = ls0;
        ls2 = ls0;
        le_err = 1'b0;
        le_found = 1'b0;
        term = 1'b0;

        if (in_valid)
        begin
            if (body_reg)
            begin
                res_valid       = 1'b1;
                res_item.length = dlen_reg;
                if (in_item.kind)
                begin
                    res_item.done_res = 1'b1;
                    res_item.status   = ST_TRUNC;
                    body_next         = 1'b0;
                    dlen_next         = '0;
                    brem_next         = '0;
                end
                else
                begin
                    res_item.is_body   = 1'b1;
                    res_item.body_byte = b;
                    brem_next          = brem_reg - 32'd1;
                    if (brem_reg == 32'd1)
                    begin
                        res_item.done_res = 1'b1;
                        body_next         = 1'b0;
                        dlen_next         = '0;
                    end
                end
            end
            else if (in_item.kind)
            begin
                res_valid         = 1'b1;
                res_item.done_res = 1'b1;
                res_item.status   = (hcount_reg == '0) ? ST_EOS : ST_HDR;
                hcount_next = '0; last4_next = '0; pcr_next = 1'b0;
                lp_next = LP_START; nidx_next = '0; nmis_next = 1'b0;
                acc_next = '0; vbad_next = 1'b0; vovf_next = 1'b0;
                herr_next = 1'b0; lfound_next = 1'b0; dlen_next = '0;
            end
            else
            begin
                if (hcount_reg != COUNT_MAX) hcount_next = hcount_reg + 21'd1;
                last4_next = {last4_reg[23:0], b};
                if (pcr_reg && b == 8'h0A)
                begin
                    // line end
                    pcr_next = 1'b0;
                    unique case (ls0.lp)
                        LP_START, LP_IGNORE: ;
                        LP_NLEAD, LP_NBODY, LP_NTRAIL, LP_VLEAD: le_err = 1'b1;
                        default:
                        begin
                            if (ls0.vbad || ls0.vovf) le_err = 1'b1;
                            else le_found = 1'b1;
                        end
                    endcase
                    ls2 = '{lp: LP_START, nidx: '0, nmis: 1'b0, acc: '0,
                            vbad: 1'b0, vovf: 1'b0};
                end
                else
                begin
                    ls1 = pcr_reg ? line_char(ls0, 8'h0D) : ls0;
                    if (b == 8'h0D)
                    begin
                        pcr_next = 1'b1;
                        ls2 = ls1;
                    end
                    else
                    begin
                        pcr_next = 1'b0;
                        ls2 = line_char(ls1, b);
                    end
                end
                lp_next = ls2.lp; nidx_next = ls2.nidx; nmis_next = ls2.nmis;
                acc_next = ls2.acc; vbad_next = ls2.vbad; vovf_next = ls2.vovf;
                herr_next = herr_reg | le_err;
                if (le_found)
                begin
                    lfound_next = 1'b1;
                    dlen_next   = ls0.acc[31:0];
                end
                term = (hcount_next >= 21'd4) && (last4_next == TERM_WORD);
                if (term || (hcount_next > max_header_bytes))
                begin
                    if (term && !herr_next && lfound_next && dlen_next <= max_body_bytes
                        && dlen_next != '0)
                    begin
                        body_next = 1'b1;
                        brem_next = dlen_next;
                    end
                    else
                    begin
                        res_valid         = 1'b1;
                        res_item.done_res = 1'b1;
                        res_item.status   = (term && !herr_next && lfound_next
                                             && dlen_next <= max_body_bytes) ? ST_OK : ST_HDR;
                        dlen_next = '0;
                    end
                    hcount_next = '0; last4_next = '0; pcr_next = 1'b0;
                    lp_next = LP_START; nidx_next = '0; nmis_next = 1'b0;
                    acc_next = '0; vbad_next = 1'b0; vovf_next = 1'b0;
                    herr_next = 1'b0; lfound_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            body_reg <= 1'b0; last4_reg <= '0; hcount_reg <= '0; pcr_reg <= 1'b0;
            lp_reg <= LP_START; nidx_reg <= '0; nmis_reg <= 1'b0; acc_reg <= '0;
            vbad_reg <= 1'b0; vovf_reg <= 1'b0; herr_reg <= 1'b0;
            lfound_reg <= 1'b0; dlen_reg <= '0; brem_reg <= '0;
        end
        else
        begin
            body_reg <= body_next; last4_reg <= last4_next; hcount_reg <= hcount_next;
            pcr_reg <= pcr_next; lp_reg <= lp_next; nidx_reg <= nidx_next;
            nmis_reg <= nmis_next; acc_reg <= acc_next; vbad_reg <= vbad_next;
            vovf_reg <= vovf_next; herr_reg <= herr_next; lfound_reg <= lfound_next;
            dlen_reg <= dlen_next; brem_reg <= brem_next;
        end
    end

endmodule

/* hdl/cld_queue.sv */
// Back part: small result queue toward the consumer.
module cld_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr,
    input  cld_pkg::out_item_t wr_item,
    input  logic               rd,
    output cld_pkg::out_item_t rd_item,
    output logic               empty,
    output logic               full
);
    import cld_pkg::*;

    out_item_t       mem_reg [QDEPTH];
    logic [QAW-1:0]  wp_reg, rp_reg;
    logic [QAW:0]    cnt_reg;
    logic            do_wr, do_rd;

    assign empty   = (cnt_reg == '0);
    assign full    = (cnt_reg == (QAW+1)'(QDEPTH));
    assign do_wr   = wr && !full;
    assign do_rd   = rd && !empty;
    assign rd_item = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr) mem_reg[wp_reg] <= wr_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end
        else
        begin
            if (do_wr) wp_reg <= wp_reg + QAW'(1);
            if (do_rd) rp_reg <= rp_reg + QAW'(1);
            cnt_reg <= cnt_reg + (QAW+1)'(do_wr) - (QAW+1)'(do_rd);
        end
    end

endmodule

/* hdl/content_length_deframer_core.sv */
// Top level: content-length header deframer core.
// Input channel: push/full with in_item (kind, data_byte). A transfer happens
// on a clock edge with push high and full low; one byte or end-of-stream event
// per cycle, sustained while full is low.
// Result channel: empty/pop with out_item. The oldest result is shown while
// empty is low; a transfer happens with pop high and empty low.
// Order: a result is registered in the staging register when its item is taken,
// then written into the 4-entry result queue; empty falls once it is there.
// Throughput: one item per cycle while full is low, set by the header parser.
// Items causing no result (header bytes) never occupy the queue.
// Stall: full rises when the result queue is full, so the front parser halts
// while the consumer does not pop; nothing is lost.
// Config: cfg_valid/cfg_ready write channel, always ready; index 0 is
// max_header_bytes, index 1 max_body_bytes.
// Reset: rst_n async low; limits return to 65536 and 16 MiB, parser empties.
module content_length_deframer_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  cld_pkg::in_item_t  in_item,
    output logic               empty,
    input  logic               pop,
    output cld_pkg::out_item_t out_item,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [0:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    import cld_pkg::*;

    logic [20:0] max_hdr_reg;
    logic [31:0] max_body_reg;
    logic        res_valid_reg;
    out_item_t   res_item_reg;
    logic        res_valid;
    out_item_t   res_item;
    logic        q_full;
    logic        accept;
    logic        qcnt_hi;
    logic        q_wr_ok;

    assign cfg_ready = 1'b1;
    // Hold off while the result queue is full, so no registered result is lost.
    assign full   = q_full || (res_valid_reg && qcnt_hi);
    assign accept = push && !full;

    // Stall input only when the queue is full and cannot take the staged result.
    assign qcnt_hi = q_full;
    assign q_wr_ok = res_valid_reg && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_hdr_reg  <= HDR_RESET;
            max_body_reg <= BODY_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index[0])
                CFG_MAX_HDR:  max_hdr_reg  <= cfg_data[20:0];
                CFG_MAX_BODY: max_body_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    cld_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (accept),
        .in_item          (in_item),
        .max_header_bytes (max_hdr_reg),
        .max_body_bytes   (max_body_reg),
        .res_valid        (res_valid),
        .res_item         (res_item)
    );

    // staging register between parser and queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (accept)
            res_valid_reg <= res_valid;
        else if (q_wr_ok)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept) res_item_reg <= res_item;
    end

    cld_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (res_valid_reg),
        .wr_item (res_item_reg),
        .rd      (pop),
        .rd_item (out_item),
        .empty   (empty),
        .full    (q_full)
    );

endmodule

/* verif/tb.sv */
// Content-length deframer core testbench: directed, limit, stall and random message tests.
module tb;
    import cld_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;   // cycles with no transfer on any port
    localparam int SETTLE_CYCLES  = 6;      // result pipeline depth plus margin
    localparam logic [8*14-1:0] CL_NAME = "content-length";
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    logic       clk;
    logic       rst_n;
    logic       push;
    logic       full;
    in_item_t   in_item;
    logic       empty;
    logic       pop;
    out_item_t  out_item;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [0:0] cfg_index;
    logic [31:0] cfg_data;

    content_length_deframer_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_item   (in_item),
        .empty     (empty),
        .pop       (pop),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Deframer shadow state, updated once per accepted input transfer
    // ------------------------------------------------------------------
    logic [20:0]  lim_hdr;
    logic [31:0]  lim_body;
    logic         in_body;
    logic [31:0]  tail_word;      // last four header bytes
    logic [20:0]  hdr_bytes;      // saturating header byte count
    logic         cr_held;        // CR waiting to see if LF follows
    line_phase_t  lphase;
    int           name_pos;
    logic         name_bad;
    logic [63:0]  val_acc;
    logic [1:0]   val_flags;      // bit0 bad char, bit1 overflow
    logic         hdr_err;
    logic         len_seen;
    logic [31:0]  msg_len;
    logic [31:0]  body_left;

    out_item_t    frame_results[$];  // expected results, oldest first

    // Test control and bookkeeping
    int send_idle;
    int recv_stall;
    int hold_cycles;
    int errors;
    int n_items;
    int n_results;
    int n_body;
    int n_status[4];
    int idle_cnt;

    task automatic clear_line();
        lphase    = LP_START;
        name_pos  = 0;
        name_bad  = 1'b0;
        val_acc   = '0;
        val_flags = '0;
    endtask

    task automatic clear_frame();
        in_body   = 1'b0;
        tail_word = '0;
        hdr_bytes = '0;
        cr_held   = 1'b0;
        clear_line();
        hdr_err   = 1'b0;
        len_seen  = 1'b0;
        msg_len   = '0;
        body_left = '0;
    endtask

    // Case-folded compare against the next expected name character
    task automatic match_name_char(input logic [7:0] c);
        logic [7:0] lc;
        lc = (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
        if (name_pos < NAME_LEN && lc == CL_NAME[8*(NAME_LEN-1-name_pos) +: 8])
            name_pos++;
        else
            name_bad = 1'b1;
    endtask

    task automatic parse_line_char(input logic [7:0] c);
        logic ws;
        logic colon;
        logic digit;
        ws    = (c == 8'h20 || c == 8'h09);
        colon = (c == 8'h3A);
        digit = (c >= 8'h30 && c <= 8'h39);
        case (lphase)
            LP_START, LP_NLEAD, LP_NBODY, LP_NTRAIL:
            begin
                if (colon)
                    lphase = (!name_bad && name_pos == NAME_LEN) ? LP_VLEAD : LP_IGNORE;
                else if (ws)
                begin
                    if (lphase == LP_START)
                        lphase = LP_NLEAD;
                    else if (lphase == LP_NBODY)
                        lphase = LP_NTRAIL;
                end
                else
                begin
                    // inner whitespace in a name spoils the match
                    if (lphase == LP_NTRAIL)
                        name_bad = 1'b1;
                    match_name_char(c);
                    lphase = LP_NBODY;
                end
            end
            LP_VLEAD, LP_VDIG:
            begin
                if (digit)
                begin
                    val_acc = val_acc * 10 + 64'(c - 8'h30);
                    if (val_acc > 64'hFFFF_FFFF)
                    begin
                        val_flags[1] = 1'b1;
                        val_acc      = 64'h1_0000_0000;
                    end
                    lphase = LP_VDIG;
                end
                else if (ws)
                begin
                    if (lphase == LP_VDIG)
                        lphase = LP_VTRAIL;
                end
                else
                    val_flags[0] = 1'b1;
            end
            LP_VTRAIL:
            begin
                if (!ws)
                    val_flags[0] = 1'b1;
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic close_line();
        case (lphase)
            LP_START, LP_IGNORE:
            begin
            end
            LP_NLEAD, LP_NBODY, LP_NTRAIL, LP_VLEAD:
                hdr_err = 1'b1;
            default:
            begin
                if (val_flags != 0)
                    hdr_err = 1'b1;
                else
                begin
                    len_seen = 1'b1;
                    msg_len  = val_acc[31:0];
                end
            end
        endcase
        clear_line();
    endtask

    // A lone CR becomes an ordinary line character
    task automatic header_byte(input logic [7:0] c);
        if (cr_held)
        begin
            if (c == CH_LF)
            begin
                cr_held = 1'b0;
                close_line();
                return;
            end
            parse_line_char(CH_CR);
        end
        if (c == CH_CR)
            cr_held = 1'b1;
        else
        begin
            cr_held = 1'b0;
            parse_line_char(c);
        end
    endtask

    // Work out the result (if any) of one accepted input transfer
    task automatic predict_frame(input in_item_t it);
        out_item_t   r;
        logic        has;
        logic [31:0] len;
        logic [1:0]  st;
        has = 1'b0;
        len = msg_len;
        if (in_body)
        begin
            has = 1'b1;
            if (it.kind)
            begin
                clear_frame();
                r = '{1'b0, 8'd0, 1'b1, ST_TRUNC, len};
            end
            else
            begin
                body_left--;
                if (body_left == 0)
                begin
                    clear_frame();
                    r = '{1'b1, it.data_byte, 1'b1, ST_OK, len};
                end
                else
                    r = '{1'b1, it.data_byte, 1'b0, ST_OK, len};
            end
        end
        else if (it.kind)
        begin
            st = (hdr_bytes == 0) ? ST_EOS : ST_HDR;
            clear_frame();
            has = 1'b1;
            r   = '{1'b0, 8'd0, 1'b1, st, 32'd0};
        end
        else
        begin
            if (hdr_bytes < COUNT_MAX)
                hdr_bytes++;
            tail_word = {tail_word[23:0], it.data_byte};
            header_byte(it.data_byte);
            // terminator wins over the size limit on the same byte
            if (hdr_bytes >= 4 && tail_word == TERM_WORD)
            begin
                len = msg_len;
                if (hdr_err || !len_seen || msg_len > lim_body)
                begin
                    clear_frame();
                    has = 1'b1;
                    r   = '{1'b0, 8'd0, 1'b1, ST_HDR, 32'd0};
                end
                else if (msg_len == 0)
                begin
                    clear_frame();
                    has = 1'b1;
                    r   = '{1'b0, 8'd0, 1'b1, ST_OK, 32'd0};
                end
                else
                begin
                    clear_frame();
                    msg_len   = len;
                    body_left = len;
                    in_body   = 1'b1;
                end
            end
            else if (hdr_bytes > lim_hdr)
            begin
                clear_frame();
                has = 1'b1;
                r   = '{1'b0, 8'd0, 1'b1, ST_HDR, 32'd0};
            end
        end
        if (has)
            frame_results = {frame_results, r};
    endtask

    // ------------------------------------------------------------------
    // Clock, reset, watchdog
    // ------------------------------------------------------------------
    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", idle_cnt);
            $display("tb failed");
            $finish;
        end
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch at result %0d: %s got 0x%0h want 0x%0h", n_results, what, got, want);
        errors++;
    endtask

    // ------------------------------------------------------------------
    // Result side: check each popped result, then choose next pop
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && pop && !empty)
        begin
            if (frame_results.size() == 0)
            begin
                $display("result %0d arrived with nothing expected", n_results);
                errors++;
            end
            else
            begin
                want = frame_results.pop_front();
                if (out_item.is_body !== want.is_body)
                    report("is_body", 32'(out_item.is_body), 32'(want.is_body));
                if (out_item.body_byte !== want.body_byte)
                    report("body_byte", 32'(out_item.body_byte), 32'(want.body_byte));
                if (out_item.done_res !== want.done_res)
                    report("done_res", 32'(out_item.done_res), 32'(want.done_res));
                if (out_item.status !== want.status)
                    report("status", 32'(out_item.status), 32'(want.status));
                if (out_item.length !== want.length)
                    report("length", out_item.length, want.length);
                if (want.is_body)
                    n_body++;
                if (want.done_res)
                    n_status[want.status]++;
            end
            n_results++;
        end
        // long hold-off counted here; otherwise random stalls
        if (hold_cycles > 0)
        begin
            hold_cycles--;
            pop <= 1'b0;
        end
        else
            pop <= ($urandom_range(0, 99) >= recv_stall);
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Leaves push high after the transfer so back-to-back items stay gapless;
    // callers that let time pass must call stop_push first.
    task automatic send_item(input logic kind, input logic [7:0] b);
        if ($urandom_range(0, 99) < send_idle)
        begin
            push <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle);
        end
        push            <= 1'b1;
        in_item.kind      <= kind;
        in_item.data_byte <= b;
        do
            @(posedge clk);
        while (full);
        predict_frame('{kind, b});
        n_items++;
    endtask

    task automatic stop_push();
        push <= 1'b0;
        @(posedge clk);
    endtask

    // Sender pauses until every expected result is back, plus pipeline margin
    task automatic drain();
        stop_push();
        while (frame_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [31:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_MAX_HDR)
            lim_hdr = value[20:0];
        else
            lim_body = value;
        cfg_valid <= 1'b0;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(1'b0, s[i]);
    endtask

    task automatic add_text(ref logic [7:0] q[$], input string s);
        for (int i = 0; i < s.len(); i++)
            q = {q, s[i]};
    endtask

    task automatic add_ws(ref logic [7:0] q[$]);
        int n;
        n = $urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0;
        repeat (n) q = {q, ($urandom_range(0, 1) ? 8'h20 : 8'h09)};
    endtask

    // One header line; content-length lines carry mixed case, padding and odd values
    task automatic add_line(ref logic [7:0] q[$]);
        int         pick;
        logic [7:0] c;
        logic [63:0] v;
        pick = $urandom_range(0, 9);
        if (pick <= 4)
        begin
            add_ws(q);
            for (int i = 0; i < NAME_LEN; i++)
            begin
                c = CL_NAME[8*(NAME_LEN-1-i) +: 8];
                if (c >= 8'h61 && c <= 8'h7A && $urandom_range(0, 1))
                    c = c - 8'h20;
                if ($urandom_range(0, 40) == 0)
                    c = 8'h78;
                q = {q, c};
            end
            add_ws(q);
            q = {q, 8'h3A};
            add_ws(q);
            case ($urandom_range(0, 9))
                0:       v = 64'hFFFF_FFFF;
                1:       v = 64'h1_0000_0000;
                2:       v = 64'd99999999999;
                3:       v = 64'($urandom);
                4:       v = 64'd0;
                default: v = 64'($urandom_range(0, 12));
            endcase
            if ($urandom_range(0, 19) != 0)
                add_text(q, $sformatf("%0d", v));
            if ($urandom_range(0, 15) == 0)
                q = {q, ($urandom_range(0, 1) ? 8'h41 : CH_CR)};
            add_ws(q);
        end
        else if (pick <= 6)
        begin
            add_text(q, "X-Tag:");
            add_ws(q);
            add_text(q, "a");
            if ($urandom_range(0, 1))
                q = {q, CH_CR};
            add_text(q, "b");
        end
        else if (pick == 8)
            add_text(q, "nocolon");
        else if (pick == 9)
            repeat ($urandom_range(1, 6)) q = {q, 8'($urandom_range(0, 255))};
        q = {q, CH_CR};
        q = {q, CH_LF};
    endtask

    // A whole message: header lines, terminator, then as much body as declared,
    // sometimes cut short by end of stream.
    task automatic send_message();
        logic [7:0] q[$];
        int         n;
        int         cut;
        repeat ($urandom_range(1, 3)) add_line(q);
        add_text(q, "\r\n");
        cut = ($urandom_range(0, 19) == 0) ? $urandom_range(0, q.size() - 1) : -1;
        foreach (q[i])
        begin
            if (i == cut)
            begin
                send_item(1'b1, 8'($urandom_range(0, 255)));
                return;
            end
            send_item(1'b0, q[i]);
        end
        if (in_body)
        begin
            if (body_left > 32'd48)
            begin
                n   = $urandom_range(0, 5);
                cut = 1;
            end
            else
            begin
                n   = int'(body_left);
                cut = 0;
                if ($urandom_range(0, 9) == 0)
                begin
                    n   = $urandom_range(0, n - 1);
                    cut = 1;
                end
            end
            repeat (n) send_item(1'b0, 8'($urandom_range(0, 255)));
            if (cut)
                send_item(1'b1, 8'($urandom_range(0, 255)));
        end
        else if ($urandom_range(0, 19) == 0)
            send_item(1'b1, 8'hFF);     // end of stream between messages
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        send_idle  = 0;
        recv_stall = 0;
        send_item(1'b1, 8'h00);                  // end of stream with nothing seen
        send_text("\r\n\r\n");                   // no length line at all
        send_text(" content-LENGTH\t:\t1 \r\n\r\n");
        send_item(1'b0, 8'hFF);                  // single body byte closes message
        send_item(1'b0, 8'h00);
        send_item(1'b1, 8'h55);                  // end of stream mid header
        drain();
    endtask

    task automatic test_limits();
        // terminator lands one byte past the limit and is still taken
        write_reg(CFG_MAX_HDR, 32'd19);
        send_text("Content-Length:0\r\n\r\n");
        write_reg(CFG_MAX_HDR, 32'd4);
        repeat (1) send_message();
        write_reg(CFG_MAX_HDR, 32'd2);           // below the terminator size
        repeat (1) send_message();
        write_reg(CFG_MAX_HDR, 32'd1048576);
        write_reg(CFG_MAX_BODY, 32'd0);          // any nonzero length is refused
        repeat (2) send_message();
        write_reg(CFG_MAX_BODY, 32'hFFFF_FFFF);
        repeat (2) send_message();
        write_reg(CFG_MAX_HDR, 32'hFFFF_FFFF);   // upper bits dropped: saturated count
        repeat (1) send_message();
        write_reg(CFG_MAX_HDR, {11'd0, HDR_RESET});
        write_reg(CFG_MAX_BODY, BODY_RESET);
        drain();
    endtask

    // Receiver holds off long enough for the result queue to fill and full to rise
    task automatic test_backpressure();
        send_idle   = 0;
        recv_stall  = 0;
        hold_cycles = 300;
        send_text("Content-Length: 40\r\n\r\n");
        repeat (40) send_item(1'b0, 8'($urandom_range(0, 255)));
        drain();
    endtask

    task automatic test_random(input int s_idle, input int r_stall, input int budget);
        int stop_at;
        send_idle  = s_idle;
        recv_stall = r_stall;
        stop_at    = n_items + budget;
        while (n_items < stop_at)
            send_message();
        drain();
    endtask

    initial
    begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        push        = 1'b0;
        pop         = 1'b0;
        in_item     = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        hold_cycles = 0;
        send_idle   = 0;
        recv_stall  = 0;
        errors      = 0;
        n_items     = 0;
        n_results   = 0;
        n_body      = 0;
        n_status    = '{0, 0, 0, 0};
        idle_cnt    = 0;
        lim_hdr     = HDR_RESET;
        lim_body    = BODY_RESET;
        clear_frame();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_limits();
        test_backpressure();
        test_random(0, 0, 50);
        write_reg(CFG_MAX_BODY, 32'd6);
        test_random(88, 0, 50);
        write_reg(CFG_MAX_HDR, 32'd40);
        test_random(0, 88, 50);
        write_reg(CFG_MAX_HDR, {11'd0, HDR_RESET});
        write_reg(CFG_MAX_BODY, BODY_RESET);
        test_random(32, 32, 50);

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("covered %0d input items, %0d results, %0d body bytes", n_items, n_results,
                 n_body);
        $display("message ends: ok %0d, header error %0d, end of stream %0d, truncated %0d",
                 n_status[0], n_status[1], n_status[2], n_status[3]);
        if (frame_results.size() != 0)
        begin
            $display("%0d expected results never arrived", frame_results.size());
            errors++;
        end
        if (errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
